// ===== src/dmm_pkg.sv =====
// ----------------------------------------------------------------------------
// Dense matrix multiply package
// Shared widths, codes, word types and helpers for the matrix multiplier.
// ----------------------------------------------------------------------------
package dmm_pkg;

  // Geometry and number formats
  localparam int MAX_DIM = 8;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DIM_W   = 4;
  localparam int VAL_W   = 16;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int ACC_W   = 40;
  localparam int CFG_IDX_W = 2;

  // Input actions
  typedef enum logic [1:0] {
    ACT_LOAD_A  = 2'd0,
    ACT_LOAD_B  = 2'd1,
    ACT_COMPUTE = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

  // Result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_WAIT,
    ST_DRAIN
  } state_t;

  // Input word
  typedef struct packed {
    logic [1:0]              action;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [ACC_W-1:0] out_value;
    logic                    status;
    logic                    last;
  } out_word_t;

  // Data wave that travels down the cell chain
  typedef struct packed {
    logic                    vld;
    logic                    first;
    logic                    fin;
    logic [IDX_W-1:0]        k;
    logic signed [VAL_W-1:0] a;
  } wave_t;

  // Clamp a dimension register to 1..MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] reg_val);
    logic [DIM_W-1:0] res;
    if (reg_val == '0) begin
      res = DIM_W'(1);
    end else if (reg_val > DIM_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = reg_val;
    end
    return res;
  endfunction

endpackage

// ===== src/dmm_cell.sv =====
// ----------------------------------------------------------------------------
// Dense matrix multiply cell
// Holds one column of B, multiplies the passing A wave against it,
// accumulates one product element and shifts results toward the output.
// ----------------------------------------------------------------------------
module dmm_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  // B column write
  input  logic                             b_we,
  input  logic [dmm_pkg::IDX_W-1:0]        b_widx,
  input  logic signed [dmm_pkg::VAL_W-1:0] b_wdata,
  // wave chain
  input  dmm_pkg::wave_t                   wave_in,
  output dmm_pkg::wave_t                   wave_out,
  // accumulator status
  output logic                             done,
  // result shift chain
  input  logic                             cap,
  input  logic                             shift,
  input  logic signed [dmm_pkg::ACC_W-1:0] sh_in,
  output logic signed [dmm_pkg::ACC_W-1:0] sh_out
);
  import dmm_pkg::*;

  logic signed [VAL_W-1:0]  b_r [MAX_DIM];
  wave_t                    wave_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     pv_r, pfirst_r, pfin_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     done_r;
  logic signed [ACC_W-1:0]  sh_r;

  // column of B, one entry per inner index
  always_ff @(posedge clk) begin
    if (b_we) begin
      b_r[b_widx] <= b_wdata;
    end
  end

  // stage 1: take the wave from the left neighbor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r.vld <= 1'b0;
    end else begin
      wave_r.vld <= wave_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    wave_r.first <= wave_in.first;
    wave_r.fin   <= wave_in.fin;
    wave_r.k     <= wave_in.k;
    wave_r.a     <= wave_in.a;
  end

  assign wave_out = wave_r;

  // stage 2: multiply against the stored B entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= wave_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    prod_r   <= wave_r.a * b_r[wave_r.k];
    pfirst_r <= wave_r.first;
    pfin_r   <= wave_r.fin;
  end

  // stage 3: accumulate, restart on the first term of a row
  always_comb begin
    acc_nxt = acc_r;
    if (pv_r) begin
      acc_nxt = pfirst_r ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= pv_r && pfin_r;
    end
  end

  assign done = done_r;

  // result shift register: capture sums, then move toward column 0
  always_ff @(posedge clk) begin
    if (cap) begin
      sh_r <= acc_r;
    end else if (shift) begin
      sh_r <= sh_in;
    end
  end

  assign sh_out = sh_r;

endmodule

// ===== src/dense_matrix_multiply.sv =====
// Load word: one per cycle while idle and no error word is stalled; an
//   out-of-shape load gives one error word on the next cycle.
// Compute word: for each product row the A row is swept through the
//   eight-cell chain, then one column word goes out per cycle while out_ready
//   is high; no new word is taken until the whole product is out.
// Reset (synchronous, active low): shape registers go to 8, sequencer idles.
// ----------------------------------------------------------------------------
// Dense matrix multiply top level
// A store, shape registers, row/column sequencer and a chain of MAC cells,
// one per product column, that emit each product row in order.
// ----------------------------------------------------------------------------
module dense_matrix_multiply (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  dmm_pkg::in_word_t                in_data,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output dmm_pkg::out_word_t               out_data,
  // configuration port
  input  logic                             cfg_we,
  input  logic [dmm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dmm_pkg::DIM_W-1:0]        cfg_data
);
  import dmm_pkg::*;

  // shape registers
  logic [DIM_W-1:0] rows_a_r, inner_len_r, cols_b_r;
  logic [DIM_W-1:0] nr, nk, nc;
  logic [IDX_W-1:0] nr_last, nk_last, nc_last;

  // sequencer
  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic             in_fire;
  logic             feed, cap, drain_shift, tail_done;

  // load decode
  logic [DIM_W-1:0] lim_row, lim_col;
  logic             is_load, in_range, a_we, b_load;

  // error word
  logic             err_vld_r, err_vld_nxt;
  logic [IDX_W-1:0] err_row_r, err_col_r;

  // A store and chain
  logic signed [VAL_W-1:0] amem [DEPTH];
  wave_t                   wave [MAX_DIM];
  logic signed [ACC_W-1:0] sh [MAX_DIM];
  logic [MAX_DIM-1:0]      b_we;

  assign in_fire  = in_valid && in_ready;

  // shape registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DIM_W'(MAX_DIM);
      inner_len_r <= DIM_W'(MAX_DIM);
      cols_b_r    <= DIM_W'(MAX_DIM);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS_A:    rows_a_r    <= cfg_data;
        CFG_INNER_LEN: inner_len_r <= cfg_data;
        CFG_COLS_B:    cols_b_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign nr = eff_dim(rows_a_r);
  assign nk = eff_dim(inner_len_r);
  assign nc = eff_dim(cols_b_r);
  assign nr_last = IDX_W'(nr - DIM_W'(1));
  assign nk_last = IDX_W'(nk - DIM_W'(1));
  assign nc_last = IDX_W'(nc - DIM_W'(1));

  // load shape check
  assign is_load  = (in_data.action == ACT_LOAD_A) || (in_data.action == ACT_LOAD_B);
  assign lim_row  = (in_data.action == ACT_LOAD_A) ? nr : nk;
  assign lim_col  = (in_data.action == ACT_LOAD_A) ? nk : nc;
  assign in_range = ({1'b0, in_data.row} < lim_row) && ({1'b0, in_data.col} < lim_col);
  assign a_we     = in_fire && (in_data.action == ACT_LOAD_A) && in_range;
  assign b_load   = in_fire && (in_data.action == ACT_LOAD_B) && in_range;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_data.action == ACT_COMPUTE) state_nxt = ST_FEED;
      end
      ST_FEED: begin
        if (k_r == nk_last) state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (tail_done) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (out_ready && j_r == nc_last) begin
          state_nxt = (i_r == nr_last) ? ST_IDLE : ST_FEED;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    feed        = (state_r == ST_FEED);
    cap         = (state_r == ST_WAIT) && tail_done;
    drain_shift = (state_r == ST_DRAIN) && out_ready;
    in_ready    = (state_r == ST_IDLE) && (!err_vld_r || out_ready);
    out_valid   = err_vld_r || (state_r == ST_DRAIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // row, column and inner counters
  always_comb begin
    i_nxt = i_r;
    j_nxt = '0;
    k_nxt = '0;
    if (in_fire) begin
      i_nxt = '0;
    end
    if (feed) begin
      k_nxt = k_r + IDX_W'(1);
    end
    if (state_r == ST_DRAIN) begin
      j_nxt = j_r;
      if (out_ready) begin
        j_nxt = j_r + IDX_W'(1);
        if (j_r == nc_last) begin
          j_nxt = '0;
          i_nxt = i_r + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
      j_r <= '0;
      k_r <= '0;
    end else begin
      i_r <= i_nxt;
      j_r <= j_nxt;
      k_r <= k_nxt;
    end
  end

  // error word for an out-of-shape load
  always_comb begin
    err_vld_nxt = err_vld_r;
    if (out_ready) err_vld_nxt = 1'b0;
    if (in_fire && is_load && !in_range) err_vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_vld_r <= 1'b0;
    end else begin
      err_vld_r <= err_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      err_row_r <= in_data.row;
      err_col_r <= in_data.col;
    end
  end

  // A store: written on A loads, read while feeding the chain
  always_ff @(posedge clk) begin
    if (a_we) begin
      amem[{in_data.row, in_data.col}] <= in_data.value;
    end
  end

  always_ff @(posedge clk) begin
    wave[0].a     <= amem[{i_r, k_r}];
    wave[0].k     <= k_r;
    wave[0].first <= (k_r == '0);
    wave[0].fin   <= (k_r == nk_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave[0].vld <= 1'b0;
    end else begin
      wave[0].vld <= feed;
    end
  end

  // cell chain, one cell per product column
  for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
    assign b_we[c] = b_load && (in_data.col == IDX_W'(c));
    if (c == MAX_DIM - 1) begin : g_tail
      dmm_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .b_we     (b_we[c]),
        .b_widx   (in_data.row),
        .b_wdata  (in_data.value),
        .wave_in  (wave[c]),
        .wave_out (),
        .done     (tail_done),
        .cap      (cap),
        .shift    (drain_shift),
        .sh_in    ('0),
        .sh_out   (sh[c])
      );
    end else begin : g_body
      dmm_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .b_we     (b_we[c]),
        .b_widx   (in_data.row),
        .b_wdata  (in_data.value),
        .wave_in  (wave[c]),
        .wave_out (wave[c+1]),
        .done     (),
        .cap      (cap),
        .shift    (drain_shift),
        .sh_in    (sh[c+1]),
        .sh_out   (sh[c])
      );
    end
  end

  // result word
  always_comb begin
    if (err_vld_r) begin
      out_data.out_row   = err_row_r;
      out_data.out_col   = err_col_r;
      out_data.out_value = '0;
      out_data.status    = STATUS_ERR;
      out_data.last      = 1'b1;
    end else begin
      out_data.out_row   = i_r;
      out_data.out_col   = j_r;
      out_data.out_value = sh[0];
      out_data.status    = STATUS_OK;
      out_data.last      = (i_r == nr_last) && (j_r == nc_last);
    end
  end

endmodule

// ===== src/dmm_checker.sv =====
// ----------------------------------------------------------------------------
// Dense matrix multiply port checker
// Watches the top-level ports for result ordering and handshake slips.
// ----------------------------------------------------------------------------
module dmm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input dmm_pkg::in_word_t             in_data,
  input logic                          out_valid,
  input logic                          out_ready,
  input dmm_pkg::out_word_t            out_data
);
  import dmm_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // an error word is a single final word with zero value
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STATUS_ERR |->
      out_data.last && out_data.out_value == '0)
    else $error("malformed error word");

  // no input taken while a product is streaming out
  a_no_in_mid_product: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STATUS_OK |-> !in_ready)
    else $error("input accepted during product output");

  // a compute word never yields a result on the next cycle
  a_compute_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.action == ACT_COMPUTE |=> !out_valid)
    else $error("result too soon after compute");

endmodule

bind dense_matrix_multiply dmm_checker u_dmm_checker (.*);

// ===== dv/dense_matrix_multiply_test.sv =====
// ----------------------------------------------------------------------------
// Dense matrix multiply testbench
// Sends element loads, product requests and shape writes to the multiplier.
// A local copy of both stores and the shape registers predicts every result
// word. The result stream is checked in order while both channels stall at
// random.
// ----------------------------------------------------------------------------
module dense_matrix_multiply_test;
  import dmm_pkg::*;

  localparam int LIMIT_CYCLES  = 2_000_000;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_WORDS  = 350;
  localparam int QUIET_WORDS   = 40;
  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_word_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data  = '0;

  // shadow shape registers and element stores
  logic [DIM_W-1:0]        rows_reg;
  logic [DIM_W-1:0]        inner_reg;
  logic [DIM_W-1:0]        cols_reg;
  logic signed [VAL_W-1:0] a_store [DEPTH];
  logic signed [VAL_W-1:0] b_store [DEPTH];
  bit [DEPTH-1:0]          a_written;
  bit [DEPTH-1:0]          b_written;

  out_word_t product_q [$];
  int        errors     = 0;
  int        cycles     = 0;
  int        words_sent = 0;
  int        ready_hold = 0;
  bit        no_idle    = 1'b0;

  dense_matrix_multiply uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Dimension actually used for a register value: 0 acts as 1, above 8 as 8
  function automatic int dim_of(logic [DIM_W-1:0] r);
    if (r == 0) return 1;
    if (r > MAX_DIM) return MAX_DIM;
    return int'(r);
  endfunction

  // Update the shadow stores and queue the result words of one input word
  function automatic void predict_word(in_word_t w);
    int        nr, nk, nc, lim_r, lim_c, addr;
    longint    acc;
    out_word_t r;
    nr = dim_of(rows_reg);
    nk = dim_of(inner_reg);
    nc = dim_of(cols_reg);
    case (w.action) inside
      ACT_LOAD_A, ACT_LOAD_B: begin
        lim_r = (w.action == ACT_LOAD_A) ? nr : nk;
        lim_c = (w.action == ACT_LOAD_A) ? nk : nc;
        if (w.row >= lim_r || w.col >= lim_c) begin
          // out of shape: nothing stored, one error word
          r = '0;
          r.out_row = w.row;
          r.out_col = w.col;
          r.status  = STATUS_ERR;
          r.last    = 1'b1;
          product_q.push_back(r);
        end else begin
          addr = w.row * MAX_DIM + w.col;
          if (w.action == ACT_LOAD_A) begin
            a_store[addr]   = w.value;
            a_written[addr] = 1'b1;
          end else begin
            b_store[addr]   = w.value;
            b_written[addr] = 1'b1;
          end
        end
      end
      ACT_COMPUTE: begin
        for (int i = 0; i < nr; i++) begin
          for (int j = 0; j < nc; j++) begin
            acc = 0;
            for (int k = 0; k < nk; k++)
              acc += longint'(a_store[i * MAX_DIM + k]) * longint'(b_store[k * MAX_DIM + j]);
            r.out_row   = IDX_W'(i);
            r.out_col   = IDX_W'(j);
            r.out_value = ACC_W'(acc);
            r.status    = STATUS_OK;
            r.last      = (i == nr - 1) && (j == nc - 1);
            product_q.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic in_word_t make_word(logic [1:0] act, int r, int c,
                                         logic [VAL_W-1:0] v);
    in_word_t w;
    w.action = act;
    w.row    = IDX_W'(r);
    w.col    = IDX_W'(c);
    w.value  = v;
    return w;
  endfunction

  // Mostly random values, with the two extremes now and then
  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      default: return VAL_W'($urandom());
    endcase
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Send one word, with an optional idle burst ahead of it; valid stays high
  // on return so that a following word can go out back to back
  task automatic send_word(in_word_t w);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    predict_word(w);
    if (w.action != ACT_NONE) words_sent++;
  endtask

  // Hold off the sender until every queued result word has come back
  task automatic wait_results();
    in_valid <= 1'b0;
    while (product_q.size() != 0) @(posedge clk);
  endtask

  // Block idle: results drained and any error word from a trailing load out
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_ROWS_A:    rows_reg  = val;
      CFG_INNER_LEN: inner_reg = val;
      CFG_COLS_B:    cols_reg  = val;
      default: ;
    endcase
  endtask

  task automatic set_shape(logic [DIM_W-1:0] r, logic [DIM_W-1:0] k,
                           logic [DIM_W-1:0] c);
    settle();
    write_reg(CFG_ROWS_A, r);
    write_reg(CFG_INNER_LEN, k);
    write_reg(CFG_COLS_B, c);
  endtask

  // Load every element the current shape reads that was never written
  task automatic fill_missing();
    int nr, nk, nc;
    nr = dim_of(rows_reg);
    nk = dim_of(inner_reg);
    nc = dim_of(cols_reg);
    for (int i = 0; i < nr; i++)
      for (int k = 0; k < nk; k++)
        if (!a_written[i * MAX_DIM + k]) send_word(make_word(ACT_LOAD_A, i, k, rand_value()));
    for (int k = 0; k < nk; k++)
      for (int j = 0; j < nc; j++)
        if (!b_written[k * MAX_DIM + j]) send_word(make_word(ACT_LOAD_B, k, j, rand_value()));
  endtask

  task automatic send_compute();
    fill_missing();
    send_word(make_word(ACT_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7),
                        VAL_W'($urandom())));
  endtask

  // Corner loads at the reset shape of 8 by 8 by 8 are in range
  task automatic test_reset_shape();
    send_word(make_word(ACT_LOAD_A, 7, 7, 16'h0100));
    send_word(make_word(ACT_LOAD_B, 7, 7, 16'hff00));
  endtask

  // 2x2x2 product with extreme operands; the sender then waits out the results
  task automatic test_small_product();
    set_shape(4'd2, 4'd2, 4'd2);
    send_word(make_word(ACT_LOAD_A, 0, 0, 16'h8000));
    send_word(make_word(ACT_LOAD_A, 0, 1, 16'h8000));
    send_word(make_word(ACT_LOAD_A, 1, 0, 16'h7fff));
    send_word(make_word(ACT_LOAD_A, 1, 1, 16'hffff));
    send_word(make_word(ACT_LOAD_B, 0, 0, 16'h8000));
    send_word(make_word(ACT_LOAD_B, 1, 0, 16'h8000));
    send_word(make_word(ACT_LOAD_B, 0, 1, 16'h7fff));
    send_word(make_word(ACT_LOAD_B, 1, 1, 16'h0001));
    send_compute();
    wait_results();
  endtask

  // Loads past each bound; the corner elements written at reset shape must
  // survive for later 8-wide products
  task automatic test_out_of_shape();
    send_word(make_word(ACT_LOAD_A, 7, 7, 16'h1234));
    send_word(make_word(ACT_LOAD_B, 7, 7, 16'h4321));
    send_word(make_word(ACT_LOAD_A, 2, 0, 16'h5555));
    send_word(make_word(ACT_LOAD_A, 0, 7, 16'haaaa));
    send_word(make_word(ACT_LOAD_B, 0, 2, 16'h0f0f));
    send_word(make_word(ACT_LOAD_B, 2, 1, 16'hf0f0));
  endtask

  // Unused action changes nothing: the product that follows is unchanged
  task automatic test_unused_action();
    send_word(make_word(ACT_NONE, 7, 7, 16'hffff));
    send_compute();
  endtask

  // Zero and oversized dimension registers, and a write to the spare index
  task automatic test_reg_clamp();
    set_shape(4'd0, 4'd0, 4'd0);
    send_compute();
    send_word(make_word(ACT_LOAD_B, 1, 0, 16'h0080));
    settle();
    write_reg(CFG_SPARE, 4'hf);
    send_compute();
    set_shape(4'hf, 4'd0, 4'd0);
    send_compute();
    send_word(make_word(ACT_LOAD_A, 7, 1, 16'h7f00));
  endtask

  // Random shapes, each followed by a burst of mostly well-formed traffic
  task automatic test_random_phases();
    int               start, burst, pick, nr, nk, nc;
    bit               is_a;
    logic [DIM_W-1:0] dims [3];
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      if (words_sent - start >= RANDOM_WORDS - QUIET_WORDS) no_idle = 1'b1;
      for (int d = 0; d < 3; d++) begin
        pick = $urandom_range(0, 15);
        if (pick == 0)      dims[d] = '0;
        else if (pick == 1) dims[d] = DIM_W'($urandom_range(9, 15));
        else if (pick == 2) dims[d] = DIM_W'(MAX_DIM);
        else                dims[d] = DIM_W'($urandom_range(1, 5));
      end
      set_shape(dims[0], dims[1], dims[2]);
      nr = dim_of(rows_reg);
      nk = dim_of(inner_reg);
      nc = dim_of(cols_reg);
      burst = $urandom_range(12, 30);
      for (int n = 0; n < burst; n++) begin
        pick = $urandom_range(0, 19);
        if (pick <= 12) begin
          // in-shape load
          is_a = 1'($urandom_range(0, 1));
          if (is_a)
            send_word(make_word(ACT_LOAD_A, $urandom_range(0, nr - 1),
                                $urandom_range(0, nk - 1), rand_value()));
          else
            send_word(make_word(ACT_LOAD_B, $urandom_range(0, nk - 1),
                                $urandom_range(0, nc - 1), rand_value()));
        end else if (pick <= 14) begin
          // any index, often out of shape
          send_word(make_word($urandom_range(0, 1) ? ACT_LOAD_A : ACT_LOAD_B,
                              $urandom_range(0, 7), $urandom_range(0, 7), rand_value()));
        end else if (pick == 15) begin
          send_word(make_word(ACT_NONE, $urandom_range(0, 7), $urandom_range(0, 7),
                              VAL_W'($urandom())));
        end else begin
          send_compute();
          if ($urandom_range(0, 3) == 0) wait_results();
        end
      end
    end
  endtask

  // Result side stalls in random bursts while no_idle is clear
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready  <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      ready_hold <= $urandom_range(0, 10);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (product_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %p", $time, out_data);
        errors++;
      end else begin
        want = product_q.pop_front();
        check_field("out_row", want.out_row, out_data.out_row);
        check_field("out_col", want.out_col, out_data.out_col);
        check_field("out_value", want.out_value, out_data.out_value);
        check_field("status", want.status, out_data.status);
        check_field("last", want.last, out_data.last);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rows_reg  = DIM_W'(MAX_DIM);
    inner_reg = DIM_W'(MAX_DIM);
    cols_reg  = DIM_W'(MAX_DIM);
    a_written = '0;
    b_written = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_shape();
    test_small_product();
    test_out_of_shape();
    test_unused_action();
    test_reg_clamp();
    test_random_phases();
    settle();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/dmm_pkg.sv
src/dmm_cell.sv
src/dense_matrix_multiply.sv
src/dmm_checker.sv
dv/dense_matrix_multiply_test.sv
